// File: rtl/cba_pkg.sv
// shared types and constants of the cubic bezier half-arc-length point block
`default_nettype none
package cba_pkg;

  localparam int unsigned SAMPLES_DEF   = 24;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned LEN_W   = 48;  // length sums
  localparam int unsigned CHORD_W = 33;  // one chord length
  localparam int unsigned DEN_W   = 34;  // divisor of the shared unit
  localparam int unsigned RAD_W   = 66;  // square root radicand
  localparam int unsigned ROOT_W  = 34;
  localparam int unsigned REM_W   = 36;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } cba_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_W_RD,
    ST_W_CHK,
    ST_F_WAIT,
    ST_P_A,
    ST_P_B,
    ST_P_C,
    ST_LX,
    ST_LY,
    ST_OUT
  } cba_state_e;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] out_dx;
    logic signed [31:0] out_dy;
    logic               has_out;
    logic signed [31:0] in_dx;
    logic signed [31:0] in_dy;
    logic               has_in;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } cba_in_t;

  typedef struct packed {
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
  } cba_res_t;

endpackage
`default_nettype wire

// File: rtl/cba_ram.sv
// generic single write port ram with registered read
`default_nettype none
module cba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/cba_iter.sv
// bit-serial shared unit: restoring divide and rounded square root
`default_nettype none
module cba_iter import cba_pkg::*; #(
  parameter int unsigned OPA_W = 66
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire cba_op_e          op_i,
  input  wire logic [OPA_W-1:0] opa_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [OPA_W-1:0] res_o
);

  localparam int unsigned CW = $clog2(OPA_W + 1);

  logic             busy_q, busy_d, done_q, done_d;
  cba_op_e          op_q, op_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [OPA_W-1:0] opa_q, opa_d;
  logic [REM_W-1:0] rem_q, rem_d, rem_sh, rem_s2, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [DEN_W-1:0] den_q, den_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    opa_d  = opa_q;
    rem_d  = rem_q;
    root_d = root_q;
    den_d  = den_q;
    rem_sh = {rem_q[REM_W-2:0], opa_q[OPA_W-1]};
    rem_s2 = {rem_q[REM_W-3:0], opa_q[OPA_W-1:OPA_W-2]};
    trial  = {root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      op_d   = op_i;
      den_d  = den_i;
      rem_d  = '0;
      root_d = '0;
      if (op_i == OP_DIV) begin
        opa_d = opa_i;
        cnt_d = CW'(OPA_W);
      end else begin
        opa_d = opa_i << (OPA_W - RAD_W);
        cnt_d = CW'(RAD_W / 2);
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        // final rounding step of the root
        if (op_q == OP_SQRT && rem_q > REM_W'(root_q)) begin
          root_d = root_q + ROOT_W'(1);
        end
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
        unique case (op_q)
          OP_DIV: begin
            if (rem_sh >= REM_W'(den_q)) begin
              rem_d = rem_sh - REM_W'(den_q);
              opa_d = {opa_q[OPA_W-2:0], 1'b1};
            end else begin
              rem_d = rem_sh;
              opa_d = {opa_q[OPA_W-2:0], 1'b0};
            end
          end
          OP_SQRT: begin
            opa_d = {opa_q[OPA_W-3:0], 2'b00};
            if (rem_s2 >= trial) begin
              rem_d  = rem_s2 - trial;
              root_d = {root_q[ROOT_W-2:0], 1'b1};
            end else begin
              rem_d  = rem_s2;
              root_d = {root_q[ROOT_W-2:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_DIV) ? opa_q : OPA_W'(root_q);

endmodule
`default_nettype wire

// File: rtl/cubic_bezier_arc_midpoint_top.sv
// top level: sequencer and datapath of the half-arc-length point of a cubic span
//
//  channel   direction  handshake           payload
//  command   in         start / busy        in_i  (cba_in_t)
//  result    out        valid_o (one cycle) res_o (cba_res_t)
//
// the bit-pair serial root and the bit-serial fraction divide take up most of the work of
// an item, and a zero-length chord skips the divide; OPA_W = max(66, 49 + FRAC_BITS)
// busy is high from the accepted item through the result strobe cycle
// the receiver cannot stall: the result stands for exactly one cycle
// reset clears the sequencer only; the sample stores need no clearing
`default_nettype none
module cubic_bezier_arc_midpoint_top import cba_pkg::*; #(
  parameter int unsigned SAMPLES   = SAMPLES_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire cba_in_t in_i,
  output logic         valid_o,
  output cba_res_t     res_o
);

  localparam int unsigned CNT_W = $clog2(SAMPLES + 1);
  localparam int unsigned LA_W  = $clog2(SAMPLES);
  localparam int unsigned W_W   = 3 * CNT_W;
  localparam int unsigned NUM_W = LEN_W + FRAC_BITS + 1;
  localparam int unsigned OPA_W = (NUM_W > RAD_W) ? NUM_W : RAD_W;
  localparam int unsigned UQ_W  = FRAC_BITS + 1;
  localparam int unsigned ACC_W = 52;
  localparam int unsigned MUL_W = 68;
  localparam logic [DEN_W-1:0] N3   = DEN_W'(SAMPLES * SAMPLES * SAMPLES);
  localparam logic [DEN_W-1:0] HALF = DEN_W'(SAMPLES * SAMPLES * SAMPLES / 2);
  localparam int unsigned N3_L = $clog2(SAMPLES * SAMPLES * SAMPLES);
  // reciprocal of n^3 scaled by 2^(N3_L + 31), below 2^32
  localparam logic [63:0] RECIP_W = (64'd1 << (N3_L + 31)) / 64'(N3);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam logic [OPA_W-1:0] ONE_F = OPA_W'(1) << FRAC_BITS;
  localparam logic [MUL_W-1:0] HALF_F = MUL_W'(1) << (FRAC_BITS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // bernstein weight of control point k at sample t
  function automatic logic [W_W-1:0] bern_w(input logic [1:0] k, input logic [CNT_W-1:0] t);
    logic [W_W-1:0] u, tt, r;
    u  = W_W'(SAMPLES) - W_W'(t);
    tt = W_W'(t);
    unique case (k)
      2'd0: r = W_W'(u * u * u);
      2'd1: r = W_W'(W_W'(3) * u * u * tt);
      2'd2: r = W_W'(W_W'(3) * u * tt * tt);
      default: r = W_W'(tt * tt * tt);
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) r = 32'sh7fffffff;
    else if (v < -34'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] lerp_fin(input logic signed [31:0] a,
                                                  input logic signed [MUL_W-1:0] p);
    logic [MUL_W-1:0] mag, r, off;
    mag = p[MUL_W-1] ? MUL_W'(-p) : MUL_W'(p);
    r   = (mag + HALF_F) >> FRAC_BITS;
    off = p[MUL_W-1] ? -r : r;
    return sat32(34'(signed'(a)) + signed'(off[33:0]));
  endfunction

  cba_state_e state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [2:0]       step_q, step_d;
  logic             axis_q, axis_d;

  logic signed [31:0] c_x_q [4];
  logic signed [31:0] c_y_q [4];
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [32:0]      qt_q, qt_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [RAD_W-1:0] sq_q, sq_d;
  logic [LEN_W-1:0] total_q, total_d, walked_q, walked_d;
  logic [UQ_W-1:0]  uq_q, uq_d;
  logic signed [31:0] ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic signed [31:0] mid_x_q, mid_x_d, mid_y_q, mid_y_d;
  logic signed [MUL_W-1:0] mul_q;
  logic signed [33:0] mul_a, mul_b;

  logic             it_start, it_done;
  cba_op_e          it_op;
  logic [OPA_W-1:0] it_opa, it_res;
  logic [DEN_W-1:0] it_den;

  logic             pt_we, len_we;
  logic [CNT_W-1:0] pt_waddr, pt_raddr;
  logic [63:0]      pt_wdata, pt_rdata;
  logic [LA_W-1:0]  len_addr;
  logic [CHORD_W-1:0] len_wdata, len_rdata;

  // combinational helpers
  logic [ACC_W-1:0] acc_mag, x_fix;
  logic [31:0]      x_sh;
  logic [32:0]      qmag, sval;
  logic signed [32:0] dx, dy;
  logic [LEN_W:0]   tot_sum, reach_sum, num49;
  logic [LEN_W-1:0] reach;
  logic signed [31:0] s_x0, s_y0, s_x3, s_y3;

  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign x_fix   = acc_mag + ACC_W'(HALF);
  assign x_sh    = 32'(x_fix >> N3_L);
  assign qmag    = qt_q;
  assign sval    = neg_q ? -qmag : qmag;
  assign dx      = 33'(px_q) - 33'(prev_x_q);
  assign dy      = 33'(py_q) - 33'(prev_y_q);
  assign tot_sum = {1'b0, total_q} + (LEN_W + 1)'(it_res[CHORD_W-1:0]);
  assign reach_sum = {1'b0, walked_q} + (LEN_W + 1)'(len_rdata);
  assign reach   = reach_sum[LEN_W] ? LEN_MAX : reach_sum[LEN_W-1:0];
  assign num49   = {1'b0, total_q} - {walked_q, 1'b0};
  assign s_x0    = in_i.start_x;
  assign s_y0    = in_i.start_y;
  assign s_x3    = in_i.end_x;
  assign s_y3    = in_i.end_y;
  assign len_addr = LA_W'(i_q - CNT_W'(1));

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    step_d   = step_q;
    axis_d   = axis_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    qt_d     = qt_q;
    px_d     = px_q;
    py_d     = py_q;
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    sq_d     = sq_q;
    total_d  = total_q;
    walked_d = walked_q;
    uq_d     = uq_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    bx_d     = bx_q;
    by_d     = by_q;
    mid_x_d  = mid_x_q;
    mid_y_d  = mid_y_q;
    mul_a    = '0;
    mul_b    = '0;
    it_start = 1'b0;
    it_op    = OP_DIV;
    it_opa   = '0;
    it_den   = N3;
    pt_we    = 1'b0;
    pt_waddr = i_q;
    pt_wdata = {px_q, py_q};
    pt_raddr = i_q;
    len_we   = 1'b0;
    len_wdata = it_res[CHORD_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          pt_we    = 1'b1;
          pt_waddr = '0;
          pt_wdata = {s_x0, s_y0};
          prev_x_d = s_x0;
          prev_y_d = s_y0;
          total_d  = '0;
          i_d      = CNT_W'(1);
          step_d   = '0;
          axis_d   = 1'b0;
          acc_d    = '0;
          state_d  = ST_MAC;
        end
      end
      ST_MAC: begin
        mul_a = 34'(signed'({1'b0, bern_w(step_q[1:0], i_q)}));
        mul_b = axis_q ? 34'(c_y_q[step_q[1:0]]) : 34'(c_x_q[step_q[1:0]]);
        if (step_q != 3'd0) begin
          acc_d = acc_q + mul_q[ACC_W-1:0];
        end
        if (step_q == 3'd4) begin
          state_d = ST_DIV_GO;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_DIV_GO: begin
        // rounded magnitude times the reciprocal of n^3
        mul_a   = signed'({2'b00, x_sh});
        mul_b   = signed'({2'b00, RECIP});
        acc_d   = signed'(x_fix);
        neg_d   = acc_q[ACC_W-1];
        step_d  = '0;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: begin
            // quotient estimate is at most four low, multiply it back
            qt_d  = mul_q[63:31];
            mul_a = signed'({1'b0, mul_q[63:31]});
            mul_b = signed'(N3);
          end
          3'd1: begin
            acc_d = acc_q - mul_q[ACC_W-1:0];
          end
          3'd6: begin
            if (!axis_q) begin
              px_d    = sval[31:0];
              axis_d  = 1'b1;
              step_d  = '0;
              acc_d   = '0;
              state_d = ST_MAC;
            end else begin
              py_d    = sval[31:0];
              step_d  = '0;
              state_d = ST_SQ;
            end
          end
          default: begin
            if ($unsigned(acc_q) >= ACC_W'(N3)) begin
              acc_d = acc_q - ACC_W'(N3);
              qt_d  = qt_q + 33'd1;
            end
          end
        endcase
      end
      ST_SQ: begin
        mul_a = 34'(dx);
        mul_b = 34'(dx);
        unique case (step_q)
          3'd0: begin
            pt_we = 1'b1;
          end
          3'd1: begin
            mul_a = 34'(dy);
            mul_b = 34'(dy);
            sq_d  = mul_q[RAD_W-1:0];
          end
          default: begin
            sq_d    = sq_q + mul_q[RAD_W-1:0];
            state_d = ST_SQRT_GO;
          end
        endcase
        step_d = step_q + 3'd1;
      end
      ST_SQRT_GO: begin
        it_start = 1'b1;
        it_op    = OP_SQRT;
        it_opa   = OPA_W'(sq_q);
        state_d  = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (it_done) begin
          len_we   = 1'b1;
          total_d  = tot_sum[LEN_W] ? LEN_MAX : tot_sum[LEN_W-1:0];
          prev_x_d = px_q;
          prev_y_d = py_q;
          step_d   = '0;
          axis_d   = 1'b0;
          acc_d    = '0;
          if (i_q == CNT_W'(SAMPLES)) begin
            i_d      = CNT_W'(1);
            walked_d = '0;
            state_d  = ST_W_RD;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_MAC;
          end
        end
      end
      ST_W_RD: begin
        state_d = ST_W_CHK;
      end
      ST_W_CHK: begin
        if ({reach, 1'b0} >= {1'b0, total_q}) begin
          if (len_rdata != '0) begin
            it_start = 1'b1;
            it_op    = OP_DIV;
            it_opa   = OPA_W'((NUM_W'(num49[LEN_W-1:0]) << FRAC_BITS) + NUM_W'(len_rdata));
            it_den   = {len_rdata, 1'b0};
            state_d  = ST_F_WAIT;
          end else begin
            uq_d    = '0;
            state_d = ST_P_A;
          end
        end else begin
          walked_d = reach;
          if (i_q == CNT_W'(SAMPLES)) begin
            // half never reached: end anchor
            mid_x_d = c_x_q[3];
            mid_y_d = c_y_q[3];
            state_d = ST_OUT;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = ST_W_RD;
          end
        end
      end
      ST_F_WAIT: begin
        if (it_done) begin
          uq_d    = (it_res > ONE_F) ? UQ_W'(ONE_F) : it_res[UQ_W-1:0];
          state_d = ST_P_A;
        end
      end
      ST_P_A: begin
        pt_raddr = i_q - CNT_W'(1);
        state_d  = ST_P_B;
      end
      ST_P_B: begin
        ax_d    = pt_rdata[63:32];
        ay_d    = pt_rdata[31:0];
        state_d = ST_P_C;
      end
      ST_P_C: begin
        bx_d    = pt_rdata[63:32];
        by_d    = pt_rdata[31:0];
        state_d = ST_LX;
      end
      ST_LX: begin
        mul_a   = 34'(bx_q) - 34'(ax_q);
        mul_b   = 34'(signed'({1'b0, uq_q}));
        state_d = ST_LY;
      end
      ST_LY: begin
        mul_a   = 34'(by_q) - 34'(ay_q);
        mul_b   = 34'(signed'({1'b0, uq_q}));
        mid_x_d = lerp_fin(ax_q, mul_q);
        state_d = ST_OUT;
        step_d  = 3'd1;
      end
      ST_OUT: begin
        // y of the lerp lands here when it came through the chord path
        if (step_q == 3'd1) begin
          mid_y_d = lerp_fin(ay_q, mul_q);
          step_d  = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      step_q  <= '0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      c_x_q[0] <= s_x0;
      c_y_q[0] <= s_y0;
      c_x_q[1] <= in_i.has_out ? sat32(34'(s_x0) + 34'(in_i.out_dx)) : s_x0;
      c_y_q[1] <= in_i.has_out ? sat32(34'(s_y0) + 34'(in_i.out_dy)) : s_y0;
      c_x_q[2] <= in_i.has_in ? sat32(34'(s_x3) + 34'(in_i.in_dx)) : s_x3;
      c_y_q[2] <= in_i.has_in ? sat32(34'(s_y3) + 34'(in_i.in_dy)) : s_y3;
      c_x_q[3] <= s_x3;
      c_y_q[3] <= s_y3;
    end
    mul_q    <= mul_a * mul_b;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    qt_q     <= qt_d;
    px_q     <= px_d;
    py_q     <= py_d;
    prev_x_q <= prev_x_d;
    prev_y_q <= prev_y_d;
    sq_q     <= sq_d;
    total_q  <= total_d;
    walked_q <= walked_d;
    uq_q     <= uq_d;
    ax_q     <= ax_d;
    ay_q     <= ay_d;
    bx_q     <= bx_d;
    by_q     <= by_d;
    mid_x_q  <= mid_x_d;
    mid_y_q  <= mid_y_d;
  end

  cba_iter #(.OPA_W(OPA_W)) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (it_start),
    .op_i    (it_op),
    .opa_i   (it_opa),
    .den_i   (it_den),
    .done_o  (it_done),
    .res_o   (it_res)
  );

  cba_ram #(.WIDTH(64), .DEPTH(SAMPLES + 1)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  cba_ram #(.WIDTH(CHORD_W), .DEPTH(SAMPLES)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_addr),
    .wdata_i (len_wdata),
    .raddr_i (len_addr),
    .rdata_o (len_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = (state_q == ST_OUT) && (step_q == 3'd0);
  assign res_o.mid_x = mid_x_q;
  assign res_o.mid_y = mid_y_q;

endmodule
`default_nettype wire

// File: rtl/cba_checker.sv
// port-level assertions for the half-arc-length point block, bound to the top level
`default_nettype none
module cba_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o
);

  // a result only shows while an item is in flight
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result strobe while idle");

  // after the result the block is free again
  a_free_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy) else $error("busy after result");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  // no result right after an item is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !valid_o) else $error("result too early");

endmodule

bind cubic_bezier_arc_midpoint_top cba_checker u_cba_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);
`default_nettype wire
